/* hw/rtl/quadratic_root_solver_macros.svh */
// Assertion macros shared by the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define QRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* hw/rtl/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Shared widths and constants for the solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;
    localparam int WordW = 32;
    localparam int TolW  = 16;
    localparam int CntW  = 2;
    localparam logic [CntW-1:0] CountNone   = 2'd0;
    localparam logic [CntW-1:0] CountDouble = 2'd1;
    localparam logic [CntW-1:0] CountTwo    = 2'd2;
    localparam logic [TolW-1:0] TolReset    = 16'd7;
endpackage

/* hw/rtl/quadratic_root_solver.sv */
// ----------------------------------------------------------------------------
// Quadratic root solver
// Roots of a*x^2+b*x+c in signed fixed point, with an interval search.
// ----------------------------------------------------------------------------
// One word enters per cycle while busy is low; busy stays low, so the block
// takes a word every clock. Each result is on the outputs with done high for
// a single cycle. The discriminant is registered at the edge that accepts
// its word. Then come one stage per square-root bit (34 stages), one stage
// that sets up the numerators, one stage per quotient bit for both roots in
// parallel (FRAC_BITS+35 stages), and an output stage. The receiver cannot
// stall.
`include "quadratic_root_solver_macros.svh"
module quadratic_root_solver #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [31:0]        coef_a,
    input  logic signed [31:0]        coef_b,
    input  logic signed [31:0]        coef_c,
    input  logic signed [31:0]        lower_bound,
    input  logic signed [31:0]        upper_bound,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [15:0]               cfg_data,
    output logic                      done,
    output logic [1:0]                root_count,
    output logic signed [31:0]        root_minus,
    output logic signed [31:0]        root_plus,
    output logic signed [31:0]        interval_root,
    output logic                      interval_found,
    output logic                      degenerate
);
    import qrs_pkg::*;

    localparam int SqN = 34;
    localparam int DW  = 68;
    localparam int NW  = 34 + FRAC_BITS;
    localparam int QN  = NW + 1;
    localparam int RW  = NW + 2;

    typedef struct packed {
        logic                 vld;
        logic                 degen;
        logic                 neg;
        logic                 dbl;
        logic [DW-1:0]        d;
        logic [SqN-1:0]       root;
        logic [SqN+2:0]       rem;
        logic signed [WordW-1:0] a;
        logic signed [WordW-1:0] b;
        logic signed [WordW-1:0] lo;
        logic signed [WordW-1:0] hi;
    } sq_t;

    typedef struct packed {
        logic [NW-1:0] n;
        logic [RW-1:0] r;
        logic [QN-1:0] q;
        logic          neg;
    } dv_t;

    typedef struct packed {
        logic                 vld;
        logic                 degen;
        logic [CntW-1:0]      cnt;
        logic [WordW:0]       den;
        dv_t                  m;
        dv_t                  p;
        logic signed [WordW-1:0] lo;
        logic signed [WordW-1:0] hi;
    } dvs_t;

    logic [TolW-1:0] tol_reg;
    sq_t  s0_reg;
    sq_t  sq_reg [SqN];
    dvs_t dv_reg [QN+1];
    sq_t  s0_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TolReset;
        end
        else if (cfg_valid)
        begin
            tol_reg <= cfg_data;
        end
    end

    // Stage zero: exact discriminant.
    logic [63:0] bb, p;
    logic [65:0] p4;
    logic        same_sign;
    logic [66:0] dsum;
    logic [66:0] tolw;
    always_comb
    begin
        bb = 64'(coef_b[31] ? -33'(coef_b) : 33'(coef_b)) *
             64'(coef_b[31] ? -33'(coef_b) : 33'(coef_b));
        p  = 64'(coef_a[31] ? -33'(coef_a) : 33'(coef_a)) *
             64'(coef_c[31] ? -33'(coef_c) : 33'(coef_c));
        p4 = {p, 2'b00};
        same_sign = (p != 64'd0) && (coef_a[31] == coef_c[31]);
        dsum = same_sign ? 67'(bb) - 67'(p4) : 67'(bb) + 67'(p4);
        tolw = 67'(tol_reg) << FRAC_BITS;
        s0_next = '0;
        s0_next.vld   = start;
        s0_next.degen = (coef_a == '0);
        s0_next.neg   = same_sign && (67'(p4) > 67'(bb));
        s0_next.d     = DW'(dsum);
        s0_next.dbl   = !s0_next.neg && (dsum < tolw);
        s0_next.a     = coef_a;
        s0_next.b     = coef_b;
        s0_next.lo    = lower_bound;
        s0_next.hi    = upper_bound;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
        end
        else
        begin
            s0_reg <= s0_next;
        end
    end

    // Square-root stages, one result bit each.
    genvar gk;
    generate
        for (gk = 0; gk < SqN; gk++)
        begin : g_sq
            sq_t src, nxt;
            logic [SqN+2:0] trial, remx;
            if (gk == 0)
            begin : g_src0
                assign src = s0_reg;
            end
            else
            begin : g_srcn
                assign src = sq_reg[gk-1];
            end
            always_comb
            begin
                nxt   = src;
                remx  = {src.rem[SqN:0], src.d[2*(SqN-1-gk)+1 -: 2]};
                trial = {1'b0, src.root, 2'b01};
                if (remx >= trial)
                begin
                    nxt.rem  = remx - trial;
                    nxt.root = {src.root[SqN-2:0], 1'b1};
                end
                else
                begin
                    nxt.rem  = remx;
                    nxt.root = {src.root[SqN-2:0], 1'b0};
                end
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_reg[gk] <= '0;
                end
                else
                begin
                    sq_reg[gk] <= nxt;
                end
            end
        end
    endgenerate

    // Numerators: quotient = floor((2n + den) / (2 den)), den = 2|a|.
    sq_t sl;
    dvs_t dv0_next;
    logic signed [35:0] nb, nm, np, sroot;
    assign sl = sq_reg[SqN-1];
    always_comb
    begin
        sroot = sl.dbl ? 36'sd0 : 36'(sl.root);
        nb = -36'(sl.b);
        nm = nb - sroot;
        np = nb + sroot;
        dv0_next = '0;
        dv0_next.vld   = sl.vld;
        dv0_next.degen = sl.degen;
        dv0_next.cnt   = (sl.degen || sl.neg) ? CountNone
                       : (sl.dbl ? CountDouble : CountTwo);
        dv0_next.den   = {(sl.a[31] ? -32'(sl.a) : 32'(sl.a)), 1'b0}
                       | {sl.a == 32'sh80000000, 32'd0};
        dv0_next.m.n   = NW'(nm[35] ? -nm : nm) << FRAC_BITS;
        dv0_next.p.n   = NW'(np[35] ? -np : np) << FRAC_BITS;
        dv0_next.m.neg = nm[35] != sl.a[31];
        dv0_next.p.neg = np[35] != sl.a[31];
        dv0_next.lo    = sl.lo;
        dv0_next.hi    = sl.hi;
    end

    // Restoring division: a divisor 2den up to 34 bits, dividend up to RW bits.
    generate
        for (gk = 0; gk <= QN; gk++)
        begin : g_dv
            dvs_t src, nxt;
            logic [RW+WordW+1:0] rm_x, rp_x, dd;
            if (gk == 0)
            begin : g_src0
                assign src = dv0_next;
            end
            else
            begin : g_srcn
                assign src = dv_reg[gk-1];
            end
            always_comb
            begin
                nxt = src;
                dd  = (RW+WordW+2)'({src.den, 1'b0}) << (QN - 1 - ((gk == 0) ? 0 : gk - 1));
                rm_x = '0;
                rp_x = '0;
                if (gk == 0)
                begin
                    nxt.m.r = RW'({src.m.n, 1'b0}) + RW'(src.den);
                    nxt.p.r = RW'({src.p.n, 1'b0}) + RW'(src.den);
                    nxt.m.q = '0;
                    nxt.p.q = '0;
                end
                else
                begin
                    rm_x = (RW+WordW+2)'(src.m.r);
                    rp_x = (RW+WordW+2)'(src.p.r);
                    if (rm_x >= dd)
                    begin
                        nxt.m.r = RW'(rm_x - dd);
                        nxt.m.q = {src.m.q[QN-2:0], 1'b1};
                    end
                    else
                    begin
                        nxt.m.q = {src.m.q[QN-2:0], 1'b0};
                    end
                    if (rp_x >= dd)
                    begin
                        nxt.p.r = RW'(rp_x - dd);
                        nxt.p.q = {src.p.q[QN-2:0], 1'b1};
                    end
                    else
                    begin
                        nxt.p.q = {src.p.q[QN-2:0], 1'b0};
                    end
                end
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_reg[gk] <= '0;
                end
                else
                begin
                    dv_reg[gk] <= nxt;
                end
            end
        end
    endgenerate

    // Sign, saturation, interval search and output register.
    dvs_t fl;
    logic signed [WordW-1:0] rm_s, rp_s, rm_v, rp_v;
    logic hit_m, hit_p;
    assign fl = dv_reg[QN];

    function automatic logic signed [WordW-1:0] sat(logic [QN-1:0] q, logic neg);
        if (neg && q != '0)
        begin
            return (q > QN'(33'h080000000)) ? 32'sh80000000 : -WordW'(q);
        end
        return (q > QN'(33'h07FFFFFFF)) ? 32'sh7FFFFFFF : WordW'(q);
    endfunction

    always_comb
    begin
        rm_s  = sat(fl.m.q, fl.m.neg);
        rp_s  = sat(fl.p.q, fl.p.neg);
        rm_v  = (fl.cnt == CountNone) ? '0 : rm_s;
        rp_v  = (fl.cnt == CountTwo) ? rp_s : '0;
        hit_m = (fl.cnt != CountNone) && (rm_v >= fl.lo) && (rm_v <= fl.hi);
        hit_p = (fl.cnt == CountTwo) && (rp_v >= fl.lo) && (rp_v <= fl.hi);
    end

    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fl.vld;
        end
    end
    always_ff @(posedge clk)
    begin
        root_count     <= fl.cnt;
        root_minus     <= rm_v;
        root_plus      <= rp_v;
        interval_root  <= hit_m ? rm_v : (hit_p ? rp_v : '0);
        interval_found <= hit_m || hit_p;
        degenerate     <= fl.degen;
    end
    assign done = done_reg;

    `QRS_ASSERT_NXT(a_done_follows, clk, rst_n, fl.vld, done, "result strobe lost")
    `QRS_ASSERT_IMP(a_degen_count, clk, rst_n, done && degenerate, root_count == CountNone,
                    "degenerate with roots")
    `QRS_ASSERT_IMP(a_found_count, clk, rst_n, done && interval_found,
                    root_count != CountNone, "interval root without roots")
endmodule
